>>> rtl/tsk_pkg.sv
// ----------------------------------------------------------------------------
// tsk_pkg
// Types and constants shared by the tagged stack cells and the top level.
// ----------------------------------------------------------------------------
package tsk_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int TAG_W         = 16;
    localparam int COORD_W       = 16;
    localparam int RECT_W        = 4 * COORD_W;
    localparam int FUNC_W        = 2;
    localparam int S_DATA_W      = 80;   // kind and four coordinates
    localparam int M_DATA_W      = 72;   // ok and four coordinates, byte padded

    typedef logic [TAG_W-1:0]  t_tag;
    typedef logic [RECT_W-1:0] t_rect;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    // per-cell control from the stack controller
    typedef struct packed {
        logic occupied;    // cell lies below the fill count
        logic wr_en;       // push lands in this cell
        logic pop_found;   // accepted pop that matched somewhere
    } t_cell_ctl;

endpackage

>>> rtl/tagged_stack_keyed_pop.sv
// ----------------------------------------------------------------------------
// tagged_stack_keyed_pop
// Bounded LIFO of tagged rectangles with pop by kind, built as a row of cells.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                       tuser
//  s        in   kind, in_x, in_y, in_w, in_h              func
//  m        out  ok, out_x, out_y, out_w, out_h, zero pad  -
//
//  One operation per cycle while a transfer is taken, that is while the
//  result register is empty or being read: each cell compares its tag, a
//  prefix-or picks the topmost match and cells at or above it shift down in
//  the same cycle. The result is registered and appears in the next cycle.
//  Synchronous active-low reset empties the stack; slot contents stay as is.
module tagged_stack_keyed_pop #(
    parameter int STACK_DEPTH = tsk_pkg::DEFAULT_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [tsk_pkg::S_DATA_W-1:0]  i_s_tdata,  // kind, in_x, in_y, in_w, in_h
    input  logic [tsk_pkg::FUNC_W-1:0]    i_s_tuser,  // func
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tsk_pkg::M_DATA_W-1:0]  o_m_tdata   // ok, out_x, out_y, out_w, out_h
);
    import tsk_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_ok;
    logic             n_ok;
    t_rect            r_out_rect;
    t_rect            n_out_rect;

    logic             w_accept;
    logic             w_full;
    logic             w_found;
    t_func            w_func;
    t_tag             w_kind;
    t_rect            w_in_rect;
    t_rect            w_pop_rect;

    logic  [STACK_DEPTH:0]   w_hit;
    t_cell_ctl               w_ctl     [STACK_DEPTH];
    t_tag                    w_tag     [STACK_DEPTH];
    t_rect                   w_rect    [STACK_DEPTH];
    t_rect                   w_sel     [STACK_DEPTH];

    assign o_s_tready = ~r_out_valid | i_m_tready;
    assign w_accept   = i_s_tvalid & o_s_tready;
    assign w_func     = t_func'(i_s_tuser);
    assign w_kind     = i_s_tdata[TAG_W-1:0];
    assign w_in_rect  = i_s_tdata[TAG_W +: RECT_W];
    assign w_full     = (r_count == CNT_W'(STACK_DEPTH));
    assign w_found    = w_hit[0];
    assign w_hit[STACK_DEPTH] = 1'b0;

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        assign w_ctl[g].occupied  = (CNT_W'(g) < r_count);
        assign w_ctl[g].wr_en     = w_accept && (w_func == FUNC_PUSH) && !w_full
                                    && (CNT_W'(g) == r_count);
        assign w_ctl[g].pop_found = w_accept && (w_func == FUNC_POP) && w_found;

        tsk_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[g]),
            .i_kind      (w_kind),
            .i_rect      (w_in_rect),
            .i_up_tag    (w_tag[(g + 1 < STACK_DEPTH) ? g + 1 : g]),
            .i_up_rect   (w_rect[(g + 1 < STACK_DEPTH) ? g + 1 : g]),
            .i_hit_above (w_hit[g + 1]),
            .o_hit       (w_hit[g]),
            .o_tag       (w_tag[g]),
            .o_rect      (w_rect[g]),
            .o_sel_rect  (w_sel[g])
        );
    end

    // at most one cell drives a non-zero rectangle
    always_comb begin
        w_pop_rect = '0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            w_pop_rect = w_pop_rect | w_sel[i];
        end
    end

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid & ~i_m_tready;
        n_ok        = r_ok;
        n_out_rect  = r_out_rect;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_ok        = 1'b0;
            n_out_rect  = '0;
            case (w_func)
                FUNC_PUSH: begin
                    if (!w_full) begin
                        n_count = r_count + 1'b1;
                        n_ok    = 1'b1;
                    end
                end
                FUNC_POP: begin
                    if (w_found) begin
                        n_count    = r_count - 1'b1;
                        n_ok       = 1'b1;
                        n_out_rect = w_pop_rect;
                    end
                end
                FUNC_CLEAR: begin
                    n_count = '0;
                    n_ok    = 1'b1;
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_ok       <= n_ok;
        r_out_rect <= n_out_rect;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W - RECT_W - 1){1'b0}}, r_out_rect, r_ok};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("fill count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_func == FUNC_PUSH && !w_full)
        |=> (r_count == $past(r_count) + 1'b1) && r_ok)
        else $error("push did not grow the stack");

    a_pop_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_func == FUNC_POP && w_found)
        |=> (r_count == $past(r_count) - 1'b1) && r_ok && o_m_tvalid)
        else $error("matched pop did not shrink the stack");

    a_pop_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_func == FUNC_POP && !w_found)
        |=> $stable(r_count) && !r_ok && (r_out_rect == '0))
        else $error("missed pop changed state or reported a rectangle");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_func == FUNC_CLEAR) |=> (r_count == '0))
        else $error("clear left entries behind");

endmodule

>>> rtl/tsk_cell.sv
// ----------------------------------------------------------------------------
// tsk_cell
// One stack slot: holds a tag and a rectangle, compares the tag against the
// searched kind and shifts down from its upper neighbour to close a gap.
// ----------------------------------------------------------------------------
module tsk_cell (
    input  logic             i_clk,
    input  tsk_pkg::t_cell_ctl i_ctl,
    input  tsk_pkg::t_tag    i_kind,
    input  tsk_pkg::t_rect   i_rect,
    input  tsk_pkg::t_tag    i_up_tag,
    input  tsk_pkg::t_rect   i_up_rect,
    input  logic             i_hit_above,
    output logic             o_hit,
    output tsk_pkg::t_tag    o_tag,
    output tsk_pkg::t_rect   o_rect,
    output tsk_pkg::t_rect   o_sel_rect
);
    import tsk_pkg::*;

    t_tag  r_tag;
    t_rect r_rect;
    t_tag  n_tag;
    t_rect n_rect;
    logic  w_match;
    logic  w_sel;
    logic  w_shift;

    assign w_match = i_ctl.occupied && (r_tag == i_kind);
    assign o_hit   = i_hit_above | w_match;
    // highest matching cell is the one with no match above it
    assign w_sel   = w_match & ~i_hit_above;
    // the removed cell and everything above it move down by one
    assign w_shift = i_ctl.pop_found & ~i_hit_above;

    always_comb begin
        n_tag  = r_tag;
        n_rect = r_rect;
        if (i_ctl.wr_en) begin
            n_tag  = i_kind;
            n_rect = i_rect;
        end else if (w_shift) begin
            n_tag  = i_up_tag;
            n_rect = i_up_rect;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_rect <= n_rect;
    end

    assign o_tag      = r_tag;
    assign o_rect     = r_rect;
    assign o_sel_rect = w_sel ? r_rect : '0;

endmodule
